[rtl/rgbpwe_pkg.sv]
// Shared types, constants and helpers for the RGB LED pulse width encoder.
package rgbpwe_pkg;

    // Bits sent from each colour field, most significant first.
    localparam int COLOUR_BITS = 8;
    localparam int PIX_BITS    = 3 * COLOUR_BITS;
    localparam int CNT_W       = $clog2(PIX_BITS + 1);

    // Depth of the pixel queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration port widths.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ONE_HIGH  = 3'd0,
        REG_ONE_LOW   = 3'd1,
        REG_ZERO_HIGH = 3'd2,
        REG_ZERO_LOW  = 3'd3,
        REG_LATCH_LOW = 3'd4
    } t_reg_idx;

    // Reset values of the timing registers.
    localparam logic [7:0]  ONE_HIGH_RST  = 8'd40;
    localparam logic [7:0]  ONE_LOW_RST   = 8'd22;
    localparam logic [7:0]  ZERO_HIGH_RST = 8'd20;
    localparam logic [7:0]  ZERO_LOW_RST  = 8'd42;
    localparam logic [15:0] LATCH_LOW_RST = 16'd2500;

    // Cell timing set, passed from the register file to the cell generator.
    typedef struct packed {
        logic [7:0]  one_high;
        logic [7:0]  one_low;
        logic [7:0]  zero_high;
        logic [7:0]  zero_low;
        logic [15:0] latch_low;
    } t_cfg;

    // A classified pixel: all colour bits in send order plus the frame flag.
    typedef struct packed {
        logic [PIX_BITS-1:0] bits;
        logic                frame_end;
    } t_pixel;

    // Handshake between the queue and the cell generator.
    typedef struct packed {
        logic   valid;
        t_pixel pixel;
    } t_q_head;

    // Cell generator sequencing.
    typedef enum logic [1:0] {
        CELL_IDLE  = 2'd0,
        CELL_DATA  = 2'd1,
        CELL_LATCH = 2'd2
    } t_cell_state;

    // Fit one colour byte to COLOUR_BITS bits; bits above the byte read as zero.
    function automatic logic [COLOUR_BITS-1:0] fit_colour(input logic [7:0] c);
        logic [COLOUR_BITS+7:0] wide;
        wide = {{COLOUR_BITS{1'b0}}, c};
        return wide[COLOUR_BITS-1:0];
    endfunction

endpackage

[rtl/rgbpwe_front.sv]
// Front end: timing register file and pixel classification into send order.
module rgbpwe_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rgbpwe_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rgbpwe_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [7:0]                      i_red,
    input  logic [7:0]                      i_green,
    input  logic [7:0]                      i_blue,
    input  logic                            i_frame_end,
    output rgbpwe_pkg::t_pixel              o_pixel,
    output rgbpwe_pkg::t_cfg                o_cfg
);

    rgbpwe_pkg::t_cfg r_cfg;
    rgbpwe_pkg::t_cfg n_cfg;

    // Writes are always taken; unknown indexes leave every register alone.
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                rgbpwe_pkg::REG_ONE_HIGH:  n_cfg.one_high  = i_cfg_data[7:0];
                rgbpwe_pkg::REG_ONE_LOW:   n_cfg.one_low   = i_cfg_data[7:0];
                rgbpwe_pkg::REG_ZERO_HIGH: n_cfg.zero_high = i_cfg_data[7:0];
                rgbpwe_pkg::REG_ZERO_LOW:  n_cfg.zero_low  = i_cfg_data[7:0];
                rgbpwe_pkg::REG_LATCH_LOW: n_cfg.latch_low = i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.one_high  <= rgbpwe_pkg::ONE_HIGH_RST;
            r_cfg.one_low   <= rgbpwe_pkg::ONE_LOW_RST;
            r_cfg.zero_high <= rgbpwe_pkg::ZERO_HIGH_RST;
            r_cfg.zero_low  <= rgbpwe_pkg::ZERO_LOW_RST;
            r_cfg.latch_low <= rgbpwe_pkg::LATCH_LOW_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

    // Lay the colours out red, green, blue, each most significant bit first.
    always_comb begin
        o_pixel.bits      = {rgbpwe_pkg::fit_colour(i_red),
                             rgbpwe_pkg::fit_colour(i_green),
                             rgbpwe_pkg::fit_colour(i_blue)};
        o_pixel.frame_end = i_frame_end;
    end

endmodule

[rtl/rgbpwe_queue.sv]
// Short pixel queue that decouples pixel intake from cell generation.
module rgbpwe_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  rgbpwe_pkg::t_pixel  i_pixel,
    output logic                o_full,
    input  logic                i_pop,
    output rgbpwe_pkg::t_q_head o_head
);

    rgbpwe_pkg::t_pixel              r_mem [rgbpwe_pkg::QUEUE_DEPTH];
    logic [rgbpwe_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [rgbpwe_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [rgbpwe_pkg::QCNT_W-1:0]   r_count;
    logic                            do_push;
    logic                            do_pop;

    assign o_full       = (r_count == rgbpwe_pkg::QCNT_W'(rgbpwe_pkg::QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.pixel = r_mem[r_rd_ptr];
    assign do_push      = i_push && !o_full;
    assign do_pop       = i_pop && o_head.valid;

    // Pointer wrap at the queue depth.
    function automatic logic [rgbpwe_pkg::QPTR_W-1:0] wrap_inc(
        input logic [rgbpwe_pkg::QPTR_W-1:0] p);
        if (p == rgbpwe_pkg::QPTR_W'(rgbpwe_pkg::QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    // Storage is payload only.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_pixel;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= wrap_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= wrap_inc(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[rtl/rgbpwe_back.sv]
// Back end: walks a pixel bit by bit and emits one line cell per output item.
module rgbpwe_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rgbpwe_pkg::t_cfg    i_cfg,
    input  rgbpwe_pkg::t_q_head i_head,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [7:0]          o_high_ticks,
    output logic [15:0]         o_low_ticks,
    output logic                o_data_bit,
    output logic                o_is_latch,
    output logic                o_last_cell
);

    rgbpwe_pkg::t_cell_state           r_state;
    rgbpwe_pkg::t_cell_state           n_state;
    logic [rgbpwe_pkg::PIX_BITS-1:0]   r_bits;
    logic                              r_frame_end;
    logic [rgbpwe_pkg::CNT_W-1:0]      r_cnt;
    logic                              r_out_valid;
    logic [7:0]                        r_high;
    logic [15:0]                       r_low;
    logic                              r_bit;
    logic                              r_latch;
    logic                              r_last;

    logic                              advance;
    logic                              emit;
    logic                              last_data;
    logic [7:0]                        n_high;
    logic [15:0]                       n_low;
    logic                              n_bit;
    logic                              n_latch;
    logic                              n_last;

    // The output register may be refilled when empty or being taken.
    assign advance   = !r_out_valid || i_ready;
    assign last_data = (r_cnt == rgbpwe_pkg::CNT_W'(1));

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rgbpwe_pkg::CELL_IDLE: begin
                if (i_head.valid) begin
                    n_state = rgbpwe_pkg::CELL_DATA;
                end
            end
            rgbpwe_pkg::CELL_DATA: begin
                if (advance && last_data) begin
                    n_state = r_frame_end ? rgbpwe_pkg::CELL_LATCH
                                          : rgbpwe_pkg::CELL_IDLE;
                end
            end
            rgbpwe_pkg::CELL_LATCH: begin
                if (advance) begin
                    n_state = rgbpwe_pkg::CELL_IDLE;
                end
            end
            default: n_state = rgbpwe_pkg::CELL_IDLE;
        endcase
    end

    // Outputs of the sequencer: queue pop and the cell about to be loaded.
    always_comb begin
        o_pop   = 1'b0;
        emit    = 1'b0;
        n_high  = i_cfg.zero_high;
        n_low   = {8'd0, i_cfg.zero_low};
        n_bit   = 1'b0;
        n_latch = 1'b0;
        n_last  = 1'b0;
        unique case (r_state)
            rgbpwe_pkg::CELL_IDLE: begin
                o_pop = i_head.valid;
            end
            rgbpwe_pkg::CELL_DATA: begin
                emit   = advance;
                n_bit  = r_bits[rgbpwe_pkg::PIX_BITS-1];
                n_high = n_bit ? i_cfg.one_high : i_cfg.zero_high;
                n_low  = {8'd0, (n_bit ? i_cfg.one_low : i_cfg.zero_low)};
                n_last = last_data && !r_frame_end;
            end
            rgbpwe_pkg::CELL_LATCH: begin
                emit    = advance;
                n_high  = 8'd0;
                n_low   = i_cfg.latch_low;
                n_latch = 1'b1;
                n_last  = 1'b1;
            end
            default: ;
        endcase
    end

    // Sequencer control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rgbpwe_pkg::CELL_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (advance) begin
                r_out_valid <= emit;
            end
        end
    end

    // Pixel shift register and remaining cell count.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_bits      <= i_head.pixel.bits;
            r_frame_end <= i_head.pixel.frame_end;
            r_cnt       <= rgbpwe_pkg::CNT_W'(rgbpwe_pkg::PIX_BITS);
        end else if (emit && (r_state == rgbpwe_pkg::CELL_DATA)) begin
            r_bits <= {r_bits[rgbpwe_pkg::PIX_BITS-2:0], 1'b0};
            r_cnt  <= r_cnt - 1'b1;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_high  <= n_high;
            r_low   <= n_low;
            r_bit   <= n_bit;
            r_latch <= n_latch;
            r_last  <= n_last;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_high_ticks = r_high;
    assign o_low_ticks  = r_low;
    assign o_data_bit   = r_bit;
    assign o_is_latch   = r_latch;
    assign o_last_cell  = r_last;

endmodule

[rtl/rgb_led_pulse_width_encoder.sv]
// Top level of the RGB LED pulse width encoder: front, pixel queue and cell generator.
//
//  Channel  | Handshake               | Payload
//  ---------+-------------------------+--------------------------------------------
//  pixel in | i_valid / o_ready       | i_red, i_green, i_blue, i_frame_end
//  cell out | o_valid / i_ready       | o_high_ticks, o_low_ticks, o_data_bit,
//           |                         | o_is_latch, o_last_cell
//  config   | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// Each pixel yields 24 cells, plus one latch cell when frame_end is set, one cell per cycle
// while i_ready holds. A pixel first leaves the queue in the idle state, then its cells go out.
// The cell generator sets the rate; a two-entry queue keeps intake open meanwhile.
// Reset is synchronous and restores the timing registers; no clearing pass is needed.
// A stalled output holds its cell while the queue keeps taking pixels until it is full.
module rgb_led_pulse_width_encoder (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rgbpwe_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rgbpwe_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [7:0]                        i_red,
    input  logic [7:0]                        i_green,
    input  logic [7:0]                        i_blue,
    input  logic                              i_frame_end,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [7:0]                        o_high_ticks,
    output logic [15:0]                       o_low_ticks,
    output logic                              o_data_bit,
    output logic                              o_is_latch,
    output logic                              o_last_cell
);

    rgbpwe_pkg::t_pixel  pixel;
    rgbpwe_pkg::t_cfg    cfg;
    rgbpwe_pkg::t_q_head head;
    logic                q_full;
    logic                pop;

    // Pixel intake is open whenever the queue has room.
    assign o_ready = !q_full;

    rgbpwe_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_red       (i_red),
        .i_green     (i_green),
        .i_blue      (i_blue),
        .i_frame_end (i_frame_end),
        .o_pixel     (pixel),
        .o_cfg       (cfg)
    );

    rgbpwe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid),
        .i_pixel (pixel),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_head  (head)
    );

    rgbpwe_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_head       (head),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_high_ticks (o_high_ticks),
        .o_low_ticks  (o_low_ticks),
        .o_data_bit   (o_data_bit),
        .o_is_latch   (o_is_latch),
        .o_last_cell  (o_last_cell)
    );

endmodule

[rtl/rgbpwe_checker.sv]
// Port-level checks for the RGB LED pulse width encoder, bound to the top level.
module rgbpwe_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [7:0]  o_high_ticks,
    input logic [15:0] o_low_ticks,
    input logic        o_data_bit,
    input logic        o_is_latch,
    input logic        o_last_cell
);

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output item valid right after reset");

    // A stalled item holds its value.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_high_ticks) && $stable(o_low_ticks)
            && $stable(o_data_bit) && $stable(o_is_latch) && $stable(o_last_cell))
        else $error("stalled output item changed");

    // A latch cell has no high phase, no data bit and closes its pixel.
    a_latch_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_latch |-> (o_high_ticks == 8'd0) && !o_data_bit && o_last_cell)
        else $error("malformed latch cell");

    // Two latch cells never follow each other: data cells always come between.
    a_no_double_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_latch && i_ready |=> !(o_valid && o_is_latch))
        else $error("latch cell followed directly by another latch cell");

endmodule

bind rgb_led_pulse_width_encoder rgbpwe_checker u_rgbpwe_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_high_ticks (o_high_ticks),
    .o_low_ticks  (o_low_ticks),
    .o_data_bit   (o_data_bit),
    .o_is_latch   (o_is_latch),
    .o_last_cell  (o_last_cell)
);
